FILE: sv/ott_pkg.sv
package ott_pkg;

    localparam int TableEntriesDefault = 4096;
    localparam int ProbeDepthDefault   = 8;
    localparam logic signed [31:0] PriceFloor = -32'sd200000;
    localparam logic [63:0] HashMul = 64'hff51afd7ed558ccd;

    typedef enum logic [2:0] {
        FUNC_ADD    = 3'd0,
        FUNC_DELETE = 3'd1,
        FUNC_EXEC   = 3'd2,
        FUNC_TRADE  = 3'd3,
        FUNC_RESET  = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_WAIT,
        ST_PROBE,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic hash_start;
        logic probe_start;
        logic probe_step;
        logic commit;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic hash_done;
        logic probe_done;
        logic drop;
        logic clear_done;
    } stat_t;

endpackage

FILE: sv/ott_hash.sv
module ott_hash #(
    parameter int TABLE_ENTRIES = ott_pkg::TableEntriesDefault
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [63:0] key,
    output logic done,
    output logic [$clog2(TABLE_ENTRIES)-1:0] slot
);
    import ott_pkg::*;
    localparam int AW = $clog2(TABLE_ENTRIES);

    logic [63:0] x_reg, acc_reg;
    logic [1:0] cnt_reg;
    logic busy_reg;
    logic [63:0] pp;
    logic [15:0] part;

    always_comb
    begin
        part = 16'(HashMul >> {cnt_reg, 4'd0});
        pp = (x_reg * {48'd0, part}) << {cnt_reg, 4'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= key ^ (key >> 33);
            acc_reg <= '0;
        end
        else if (busy_reg)
            acc_reg <= acc_reg + pp;
    end

    logic [63:0] fin;
    assign fin = acc_reg ^ (acc_reg >> 33);
    assign slot = fin[AW-1:0];
endmodule

FILE: sv/ott_datapath.sv
module ott_datapath #(
    parameter int TABLE_ENTRIES = ott_pkg::TableEntriesDefault,
    parameter int PROBE_DEPTH   = ott_pkg::ProbeDepthDefault
) (
    input  logic clk,
    input  logic rst_n,
    input  ott_pkg::ctrl_t ctrl,
    output ott_pkg::stat_t stat,
    input  logic [2:0] func,
    input  logic [63:0] order_key,
    input  logic [1:0] side_code,
    input  logic signed [31:0] price_ticks,
    input  logic [31:0] quantity,
    input  logic [31:0] queue_priority,
    input  logic intermediate_flag,
    output logic [2:0] event_kind,
    output logic [63:0] event_key,
    output logic [1:0] event_side,
    output logic signed [31:0] event_price,
    output logic [31:0] event_quantity,
    output logic [31:0] remaining_size,
    output logic [31:0] event_priority,
    output logic event_intermediate,
    output logic key_found,
    output logic table_full
);
    import ott_pkg::*;
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int PW = $clog2(PROBE_DEPTH + 1);

    logic [2:0] func_reg;
    logic [63:0] key_reg;
    logic [1:0] side_reg;
    logic signed [31:0] price_reg;
    logic [31:0] qty_reg, prio_reg;
    logic inter_reg;

    logic mvalid [TABLE_ENTRIES];
    logic [63:0] mkey [TABLE_ENTRIES];
    logic [31:0] mprice [TABLE_ENTRIES];
    logic [31:0] msize [TABLE_ENTRIES];

    logic clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] home;
    logic hdone;
    logic [AW-1:0] addr_reg, hit_reg, free_reg;
    logic [PW-1:0] cnt_reg;
    logic rd_pend_reg, hit_v_reg, free_v_reg;
    logic [AW-1:0] rd_addr_reg;
    logic rd_valid_reg;
    logic [63:0] rd_key_reg;
    logic [31:0] rd_price_reg, rd_size_reg, hit_price_reg, hit_size_reg;

    ott_hash #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_hash (
        .clk(clk), .rst_n(rst_n), .start(ctrl.hash_start), .key(key_reg),
        .done(hdone), .slot(home)
    );

    assign stat.hash_done = hdone;
    assign stat.probe_done = !rd_pend_reg && cnt_reg == PW'(PROBE_DEPTH);
    assign stat.drop = func_reg > FUNC_RESET
        || (func_reg == FUNC_ADD && price_reg <= PriceFloor);
    assign stat.clear_done = !clr_busy_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            func_reg <= func;
            key_reg <= order_key;
            side_reg <= side_code;
            price_reg <= price_ticks;
            qty_reg <= quantity;
            prio_reg <= queue_priority;
            inter_reg <= intermediate_flag;
        end
        rd_key_reg <= mkey[addr_reg];
        rd_price_reg <= mprice[addr_reg];
        rd_size_reg <= msize[addr_reg];
        rd_valid_reg <= mvalid[addr_reg];
        rd_addr_reg <= addr_reg;
        if (rd_pend_reg && rd_valid_reg && rd_key_reg == key_reg && !hit_v_reg)
        begin
            hit_reg <= rd_addr_reg;
            hit_price_reg <= rd_price_reg;
            hit_size_reg <= rd_size_reg;
        end
        if (rd_pend_reg && !rd_valid_reg && !free_v_reg)
            free_reg <= rd_addr_reg;
        if (ctrl.commit && func_reg == FUNC_ADD && (hit_v_reg || free_v_reg))
        begin
            mkey[hit_v_reg ? hit_reg : free_reg] <= key_reg;
            mprice[hit_v_reg ? hit_reg : free_reg] <= price_reg;
            msize[hit_v_reg ? hit_reg : free_reg] <= qty_reg;
        end
        if (ctrl.commit && (func_reg == FUNC_EXEC || func_reg == FUNC_TRADE)
            && hit_v_reg && hit_size_reg >= qty_reg)
            msize[hit_reg] <= hit_size_reg - qty_reg;
        if (clr_busy_reg)
            mvalid[clr_addr_reg] <= 1'b0;
        else if (ctrl.commit)
        begin
            if (func_reg == FUNC_ADD && (hit_v_reg || free_v_reg))
                mvalid[hit_v_reg ? hit_reg : free_reg] <= 1'b1;
            if (func_reg == FUNC_DELETE && hit_v_reg)
                mvalid[hit_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
            hit_v_reg <= 1'b0;
            free_v_reg <= 1'b0;
            addr_reg <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(TABLE_ENTRIES - 1))
                    clr_busy_reg <= 1'b0;
            end
            if (ctrl.probe_start)
            begin
                addr_reg <= home;
                cnt_reg <= '0;
                hit_v_reg <= 1'b0;
                free_v_reg <= 1'b0;
                rd_pend_reg <= 1'b0;
            end
            else if (ctrl.probe_step)
            begin
                rd_pend_reg <= cnt_reg != PW'(PROBE_DEPTH);
                if (cnt_reg != PW'(PROBE_DEPTH))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    addr_reg <= addr_reg + 1'b1;
                end
                if (rd_pend_reg && rd_valid_reg && rd_key_reg == key_reg)
                    hit_v_reg <= 1'b1;
                if (rd_pend_reg && !rd_valid_reg)
                    free_v_reg <= 1'b1;
            end
        end
    end

    logic ex, fits;
    assign ex = func_reg == FUNC_EXEC || func_reg == FUNC_TRADE;
    assign fits = hit_size_reg >= qty_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            event_kind <= func_reg;
            event_intermediate <= inter_reg;
            event_key <= func_reg == FUNC_RESET ? 64'd0 : key_reg;
            if (func_reg == FUNC_RESET)
                event_side <= 2'd0;
            else if (ex)
                event_side <= side_reg == 2'd0 ? 2'd1 : (side_reg == 2'd1 ? 2'd0 : 2'd2);
            else
                event_side <= side_reg == 2'd3 ? 2'd2 : side_reg;
            if (func_reg == FUNC_ADD || func_reg == FUNC_TRADE)
                event_price <= price_reg;
            else if (func_reg == FUNC_EXEC && hit_v_reg)
                event_price <= hit_price_reg;
            else
                event_price <= '0;
            event_quantity <= (func_reg == FUNC_ADD || ex) ? qty_reg : 32'd0;
            event_priority <= func_reg == FUNC_ADD ? prio_reg : 32'd0;
            if (ex && hit_v_reg)
                remaining_size <= fits ? hit_size_reg - qty_reg : hit_size_reg;
            else
                remaining_size <= '0;
            key_found <= func_reg != FUNC_RESET && hit_v_reg;
            table_full <= func_reg == FUNC_ADD && !hit_v_reg && !free_v_reg;
        end
    end
endmodule

FILE: sv/ott_ctrl.sv
module ott_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  ott_pkg::stat_t stat,
    output ott_pkg::ctrl_t ctrl
);
    import ott_pkg::*;
    state_t state_reg, state_next;
    logic ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        ctrl = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = stat.clear_done;
                if (in_valid && stat.clear_done)
                begin
                    ctrl.load = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (stat.drop)
                    state_next = ST_IDLE;
                else
                begin
                    ctrl.hash_start = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (stat.hash_done)
                begin
                    ctrl.probe_start = 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                ctrl.probe_step = 1'b1;
                if (stat.probe_done)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                ctrl.probe_step = 1'b0;
                if (!ov_next)
                begin
                    ctrl.commit = 1'b1;
                    ctrl.out_load = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

FILE: sv/order_table_tracker_core.sv
// Each request is registered, hashed by the four-step multiply and then
// probed serially through the table port over PROBE_DEPTH slots before
// the result is written; a new request is taken only once the last is done.
// Dropped requests return to idle with no result. The output register
// holds one result. Reset clears control state; a pass over every entry
// then clears the entry valid bits before the first request is accepted.
module order_table_tracker_core #(
    parameter int TABLE_ENTRIES = ott_pkg::TableEntriesDefault,
    parameter int PROBE_DEPTH   = ott_pkg::ProbeDepthDefault
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [2:0] func,
    input  logic [63:0] order_key,
    input  logic [1:0] side_code,
    input  logic signed [31:0] price_ticks,
    input  logic [31:0] quantity,
    input  logic [31:0] queue_priority,
    input  logic intermediate_flag,
    output logic out_valid,
    input  logic out_ready,
    output logic [2:0] event_kind,
    output logic [63:0] event_key,
    output logic [1:0] event_side,
    output logic signed [31:0] event_price,
    output logic [31:0] event_quantity,
    output logic [31:0] remaining_size,
    output logic [31:0] event_priority,
    output logic event_intermediate,
    output logic key_found,
    output logic table_full
);
    import ott_pkg::*;
    ctrl_t ctrl;
    stat_t stat;

    ott_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .ctrl(ctrl)
    );

    ott_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .PROBE_DEPTH(PROBE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
        .func(func), .order_key(order_key), .side_code(side_code),
        .price_ticks(price_ticks), .quantity(quantity),
        .queue_priority(queue_priority), .intermediate_flag(intermediate_flag),
        .event_kind(event_kind), .event_key(event_key), .event_side(event_side),
        .event_price(event_price), .event_quantity(event_quantity),
        .remaining_size(remaining_size), .event_priority(event_priority),
        .event_intermediate(event_intermediate), .key_found(key_found),
        .table_full(table_full)
    );
endmodule
